>>> rtl/cpec_pkg.sv
// Shared types, state codes and helper functions for the circle pair collision block.
package cpec_pkg;

   typedef logic signed [39:0] wide_type;

   typedef enum logic [21:0] {
      ST_CLEAR = 22'h000001,
      ST_IDLE  = 22'h000002,
      ST_MOD   = 22'h000004,
      ST_SQX   = 22'h000008,
      ST_SQY   = 22'h000010,
      ST_SQR   = 22'h000020,
      ST_RDM   = 22'h000040,
      ST_DEC   = 22'h000080,
      ST_SQRT  = 22'h000100,
      ST_DNX   = 22'h000200,
      ST_DNY   = 22'h000400,
      ST_DW1   = 22'h000800,
      ST_DW2   = 22'h001000,
      ST_MRX   = 22'h002000,
      ST_MRY   = 22'h004000,
      ST_MK1   = 22'h008000,
      ST_MK2   = 22'h010000,
      ST_M1X   = 22'h020000,
      ST_M1Y   = 22'h040000,
      ST_M2X   = 22'h080000,
      ST_M2Y   = 22'h100000,
      ST_OUT   = 22'h200000
   } state_type;

   function automatic logic [35:0] mag36(input wide_type v);
      wide_type t;
      t = v[39] ? -v : v;
      return t[35:0];
   endfunction

   function automatic logic [31:0] sat32(input wide_type v);
      logic [31:0] r;
      if (v > wide_type'(40'sh007FFFFFFF)) begin
         r = 32'h7FFFFFFF;
      end else if (v < -wide_type'(40'sh0080000000)) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/circle_pair_elastic_collision.sv
// Circle pair elastic collision: sequencer over shared multiplier, divider and root units.
// Every beat runs the squaring multiplies; one that applies an impulse also runs four divisions
// (two when both masses are zero), a root and eight multiplies.
// A new beat is accepted only once the previous one is done; a result waiting in the output
// register holds the block in its output step. Synchronous reset clears control state and
// then sweeps all PAIR_SLOTS entries of the mark store to zero with no beat accepted.
module circle_pair_elastic_collision
   import cpec_pkg::*;
#(
   parameter int PAIR_SLOTS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x, first_vel_y,
   // second_vel_x, second_vel_y, first_mass, second_mass, radius_sum, pair_slot
   input  logic [367:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y,
   // overlapping, impulse_applied
   output logic [135:0] rsp_tdata
);

   localparam int AW        = $clog2(PAIR_SLOTS);
   localparam int MOD_SH    = 10 + $clog2(PAIR_SLOTS);
   localparam int MOD_RECIP = ((1 << MOD_SH) + PAIR_SLOTS - 1) / PAIR_SLOTS;

   state_type state_ff, state_in;
   logic      go_ff, go_in;
   logic [AW-1:0] clr_ff;
   logic      rsp_valid_ff;
   logic [135:0] rsp_data_ff;

   logic signed [32:0] dx_ff, dy_ff, rx_ff, ry_ff;
   logic signed [31:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic [31:0] m1_ff, m2_ff, rs_ff;
   logic [9:0]  slot_raw_ff;
   logic [AW-1:0] slot_ff;
   logic [64:0] dist2_ff;
   logic        overlap_ff, applied_ff;
   logic [31:0] dist_ff, w1_ff, w2_ff;
   logic signed [31:0] nx_ff, ny_ff;
   wide_type    j_ff, k1_ff, k2_ff, n1x_ff, n1y_ff, n2x_ff, n2y_ff;

   logic [31:0] sx, sy;
   logic [32:0] msum;
   logic [31:0] mod_prod;
   logic [9:0]  mod_q;
   logic [31:0] mod_rem;
   logic        is_mul, is_div, is_sqrt, step_done, accept;
   logic [35:0] mul_a;
   logic [31:0] mul_b;
   logic        mul_neg, mul_done;
   logic [67:0] mul_p;
   wide_type    prodval;
   logic [63:0] div_num;
   logic [32:0] div_den;
   logic        div_done;
   logic [31:0] div_q;
   logic        sqrt_done;
   logic [31:0] sqrt_root;
   logic        ram_we, ram_wdata, mark;
   logic [AW-1:0] ram_waddr;
   logic signed [31:0] nq;

   assign sx   = dx_ff[32] ? 32'(-dx_ff) : dx_ff[31:0];
   assign sy   = dy_ff[32] ? 32'(-dy_ff) : dy_ff[31:0];
   assign msum = {1'b0, m1_ff} + {1'b0, m2_ff};

   // The slot wrap uses a reciprocal multiply that is exact for every 10-bit slot.
   assign mod_prod = 32'(slot_raw_ff) * 32'(MOD_RECIP);
   assign mod_q    = 10'(mod_prod >> MOD_SH);
   assign mod_rem  = 32'(slot_raw_ff) - 32'(mod_q) * 32'(PAIR_SLOTS);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_mul  = 1'b0;
      is_div  = 1'b0;
      is_sqrt = 1'b0;
      mul_a   = {4'b0, sx};
      mul_b   = sx;
      mul_neg = 1'b0;
      div_num = {54'b0, slot_raw_ff};
      div_den = 33'(PAIR_SLOTS);
      case (state_ff)
         ST_SQX: is_mul = 1'b1;
         ST_SQY: begin
            is_mul = 1'b1;
            mul_a  = {4'b0, sy};
            mul_b  = sy;
         end
         ST_SQR: begin
            is_mul = 1'b1;
            mul_a  = {4'b0, rs_ff};
            mul_b  = rs_ff;
         end
         ST_SQRT: is_sqrt = 1'b1;
         ST_DNX: begin
            is_div  = 1'b1;
            div_num = {2'b0, sx, 30'b0};
            div_den = {1'b0, dist_ff};
         end
         ST_DNY: begin
            is_div  = 1'b1;
            div_num = {2'b0, sy, 30'b0};
            div_den = {1'b0, dist_ff};
         end
         ST_DW1: begin
            is_div  = 1'b1;
            div_num = {1'b0, m1_ff, 31'b0};
            div_den = msum;
         end
         ST_DW2: begin
            is_div  = 1'b1;
            div_num = {1'b0, m2_ff, 31'b0};
            div_den = msum;
         end
         ST_MRX: begin
            is_mul  = 1'b1;
            mul_a   = mag36(wide_type'(rx_ff));
            mul_b   = 32'(mag36(wide_type'(nx_ff)));
            mul_neg = rx_ff[32] ^ nx_ff[31];
         end
         ST_MRY: begin
            is_mul  = 1'b1;
            mul_a   = mag36(wide_type'(ry_ff));
            mul_b   = 32'(mag36(wide_type'(ny_ff)));
            mul_neg = ry_ff[32] ^ ny_ff[31];
         end
         ST_MK1: begin
            is_mul  = 1'b1;
            mul_a   = mag36(j_ff);
            mul_b   = w2_ff;
            mul_neg = j_ff[39];
         end
         ST_MK2: begin
            is_mul  = 1'b1;
            mul_a   = mag36(j_ff);
            mul_b   = w1_ff;
            mul_neg = j_ff[39];
         end
         ST_M1X: begin
            is_mul  = 1'b1;
            mul_a   = mag36(k1_ff);
            mul_b   = 32'(mag36(wide_type'(nx_ff)));
            mul_neg = k1_ff[39] ^ nx_ff[31];
         end
         ST_M1Y: begin
            is_mul  = 1'b1;
            mul_a   = mag36(k1_ff);
            mul_b   = 32'(mag36(wide_type'(ny_ff)));
            mul_neg = k1_ff[39] ^ ny_ff[31];
         end
         ST_M2X: begin
            is_mul  = 1'b1;
            mul_a   = mag36(k2_ff);
            mul_b   = 32'(mag36(wide_type'(nx_ff)));
            mul_neg = k2_ff[39] ^ nx_ff[31];
         end
         ST_M2Y: begin
            is_mul  = 1'b1;
            mul_a   = mag36(k2_ff);
            mul_b   = 32'(mag36(wide_type'(ny_ff)));
            mul_neg = k2_ff[39] ^ ny_ff[31];
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
   end

   assign prodval   = mul_neg ? -wide_type'({2'b0, mul_p[67:30]})
                              : wide_type'({2'b0, mul_p[67:30]});
   assign step_done = go_ff && (mul_done || div_done || sqrt_done);
   assign go_in     = (is_mul || is_div || is_sqrt) && !step_done;
   assign nq        = div_q;

   cpec_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (is_mul && !go_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   cpec_div u_div (
      .clock (clock),
      .reset (reset),
      .start (is_div && !go_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   cpec_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (is_sqrt && !go_ff),
      .x     (dist2_ff[63:0]),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign ram_we    = (state_ff == ST_CLEAR) ||
                      ((state_ff == ST_DEC) && (!overlap_ff || !mark));
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_ff : slot_ff;
   assign ram_wdata = (state_ff == ST_CLEAR) ? 1'b0 : overlap_ff;

   cpec_ram #(
      .WIDTH (1),
      .DEPTH (PAIR_SLOTS)
   ) u_marks (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (slot_ff),
      .rdata (mark)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(PAIR_SLOTS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_tvalid) state_in = ST_MOD;
         ST_MOD:   state_in = ST_SQX;
         ST_SQX:   if (step_done) state_in = ST_SQY;
         ST_SQY:   if (step_done) state_in = ST_SQR;
         ST_SQR:   if (step_done) state_in = ST_RDM;
         ST_RDM:   state_in = ST_DEC;
         ST_DEC: begin
            if (!overlap_ff || mark || (dist2_ff == 65'd0)) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT:  if (step_done) state_in = ST_DNX;
         ST_DNX:   if (step_done) state_in = ST_DNY;
         ST_DNY: begin
            if (step_done) begin
               state_in = (msum == 33'd0) ? ST_MRX : ST_DW1;
            end
         end
         ST_DW1:   if (step_done) state_in = ST_DW2;
         ST_DW2:   if (step_done) state_in = ST_MRX;
         ST_MRX:   if (step_done) state_in = ST_MRY;
         ST_MRY:   if (step_done) state_in = ST_MK1;
         ST_MK1:   if (step_done) state_in = ST_MK2;
         ST_MK2:   if (step_done) state_in = ST_M1X;
         ST_M1X:   if (step_done) state_in = ST_M1Y;
         ST_M1Y:   if (step_done) state_in = ST_M2X;
         ST_M2X:   if (step_done) state_in = ST_M2Y;
         ST_M2Y:   if (step_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         go_ff        <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff       <= $signed({req_tdata[31], req_tdata[31:0]})
                      - $signed({req_tdata[95], req_tdata[95:64]});
         dy_ff       <= $signed({req_tdata[63], req_tdata[63:32]})
                      - $signed({req_tdata[127], req_tdata[127:96]});
         rx_ff       <= $signed({req_tdata[159], req_tdata[159:128]})
                      - $signed({req_tdata[223], req_tdata[223:192]});
         ry_ff       <= $signed({req_tdata[191], req_tdata[191:160]})
                      - $signed({req_tdata[255], req_tdata[255:224]});
         v1x_ff      <= req_tdata[159:128];
         v1y_ff      <= req_tdata[191:160];
         v2x_ff      <= req_tdata[223:192];
         v2y_ff      <= req_tdata[255:224];
         m1_ff       <= req_tdata[287:256];
         m2_ff       <= req_tdata[319:288];
         rs_ff       <= req_tdata[351:320];
         slot_raw_ff <= req_tdata[361:352];
         n1x_ff      <= wide_type'($signed(req_tdata[159:128]));
         n1y_ff      <= wide_type'($signed(req_tdata[191:160]));
         n2x_ff      <= wide_type'($signed(req_tdata[223:192]));
         n2y_ff      <= wide_type'($signed(req_tdata[255:224]));
      end
      if (state_ff == ST_MOD) begin
         slot_ff <= mod_rem[AW-1:0];
      end
      if (step_done) begin
         case (state_ff)
            ST_SQX:  dist2_ff <= {1'b0, mul_p[63:0]};
            ST_SQY:  dist2_ff <= dist2_ff + {1'b0, mul_p[63:0]};
            ST_SQR:  overlap_ff <= !dist2_ff[64] && (dist2_ff[63:0] < mul_p[63:0]);
            ST_SQRT: dist_ff <= sqrt_root;
            ST_DNX:  nx_ff <= dx_ff[32] ? -nq : nq;
            ST_DNY: begin
               ny_ff <= dy_ff[32] ? -nq : nq;
               w1_ff <= 32'd0;
               w2_ff <= 32'd0;
            end
            ST_DW1:  w1_ff  <= div_q;
            ST_DW2:  w2_ff  <= div_q;
            ST_MRX:  j_ff   <= prodval;
            ST_MRY:  j_ff   <= j_ff + prodval;
            ST_MK1:  k1_ff  <= prodval;
            ST_MK2:  k2_ff  <= prodval;
            ST_M1X:  n1x_ff <= n1x_ff - prodval;
            ST_M1Y:  n1y_ff <= n1y_ff - prodval;
            ST_M2X:  n2x_ff <= n2x_ff + prodval;
            ST_M2Y:  n2y_ff <= n2y_ff + prodval;
            default: dist_ff <= dist_ff;
         endcase
      end
      if (state_ff == ST_DEC) begin
         applied_ff <= overlap_ff && !mark && (dist2_ff != 65'd0);
      end
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {6'b0, applied_ff, overlap_ff, sat32(n2y_ff), sat32(n2x_ff),
                         sat32(n1y_ff), sat32(n1x_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output step");

   a_impulse_needs_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[129] && !rsp_tdata[128]))
      else $error("impulse reported without overlap");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR))
      else $error("reset did not start the mark sweep");

   a_mark_write_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_DEC)))
      else $error("mark store written outside sweep or decision");
`endif

endmodule

>>> rtl/cpec_ram.sv
// Generic single-port-write, registered-read RAM.
module cpec_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/cpec_mul.sv
// Shared unsigned 36 by 32 bit multiplier built from two passes of a 32 by 32 product.
module cpec_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [35:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [67:0] p
);

   logic        busy_ff;
   logic        done_ff;
   logic [1:0]  phase_ff;
   logic [35:0] a_ff;
   logic [31:0] b_ff;
   logic [63:0] prod_ff;
   logic [67:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 2'd0;
         end else if (busy_ff) begin
            case (phase_ff)
               2'd0: phase_ff <= 2'd1;
               2'd1: phase_ff <= 2'd2;
               default: begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end else if (busy_ff) begin
         case (phase_ff)
            2'd0: prod_ff <= a_ff[31:0] * b_ff;
            2'd1: begin
               acc_ff  <= {4'b0, prod_ff};
               prod_ff <= {28'b0, a_ff[35:32]} * b_ff;
            end
            default: acc_ff <= acc_ff + {prod_ff[35:0], 32'b0};
         endcase
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

>>> rtl/cpec_div.sv
// Shared restoring divider giving one quotient bit per cycle, 32 quotient bits.
module cpec_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic        done,
   output logic [31:0] quo
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [31:0] low_ff;
   logic [31:0] q_ff;
   logic [32:0] den_ff;
   logic [33:0] trial;
   logic        ge;

   assign trial = {rem_ff, low_ff[31]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num[63:32]};
         low_ff <= num[31:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         q_ff   <= {q_ff[30:0], ge};
         low_ff <= {low_ff[30:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

>>> rtl/cpec_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module cpec_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [34:0] rem_ff;
   logic [31:0] root_ff;
   logic [34:0] r;
   logic [34:0] trial;
   logic        ge;

   assign r     = {rem_ff[32:0], x_ff[63:62]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = r >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= x;
         rem_ff  <= 35'd0;
         root_ff <= 32'd0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? r - trial : r;
         root_ff <= {root_ff[30:0], ge};
         x_ff    <= {x_ff[61:0], 2'b00};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
